/* rtl/swq_pkg.sv */
// Shared types, constants and helpers for the serial register write queue.
`default_nettype none

package swq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;

    localparam logic [BIT_IDX_W-1:0] BIT_IDX_MSB = BIT_IDX_W'(BYTE_W - 1);

    // request kinds carried on tuser
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_SEND_ADDR   = 3'd1,
        PH_STROBE_ADDR = 3'd2,
        PH_SEND_DATA   = 3'd3,
        PH_STROBE_DATA = 3'd4
    } phase_t;

    typedef logic [PTR_W-1:0] ptr_t;

    // pin levels and busy flag after one request
    typedef struct packed {
        logic busy;
        logic latch;
        logic data;
        logic clock;
    } ser_stat_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/serial_register_write_queue.sv */
// Top level: ring queue of register writes feeding the three-wire serializer.
// An accepted request's result is registered and is presented on the master side in the following cycle.
// Throughput: one request per clock while the result is taken (m_tready high); the queue and serializer update in the
// accept cycle and the result register decouples the output handshake.
// Reset (rst_n low, async): pointers zero, serializer idle, clock and latch high,
// data low; queue entries are not cleared.
`default_nettype none

module serial_register_write_queue
    import swq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // reg_addr[7:0], reg_data[15:8]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // serial_clock, serial_data, latch_pin,
                                        // busy_res, queue_empty, zero pad[7:5]
);

    logic [BYTE_W-1:0] addr_mem_reg [QUEUE_DEPTH];
    logic [BYTE_W-1:0] data_mem_reg [QUEUE_DEPTH];
    ptr_t              wr_ptr_reg, wr_ptr_next;
    ptr_t              rd_ptr_reg, rd_ptr_next;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              accept;
    logic              enq;
    logic              tick;
    logic              rd_adv;
    ser_stat_t         stat_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign enq      = accept && (s_tuser == REQ_ENQUEUE);
    assign tick     = accept && (s_tuser == REQ_TICK);

    swq_ser u_ser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .pending   (rd_ptr_reg != wr_ptr_reg),
        .addr_byte (addr_mem_reg[rd_ptr_reg]),
        .data_byte (data_mem_reg[rd_ptr_reg]),
        .stat_next (stat_next),
        .rd_adv    (rd_adv)
    );

    assign wr_ptr_next = enq    ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next = rd_adv ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;

    // no full check: an enqueue with 15 entries pending makes the pointers equal, so the queue reads as empty
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            addr_mem_reg[wr_ptr_reg] <= s_tdata[7:0];
            data_mem_reg[wr_ptr_reg] <= s_tdata[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (accept)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {3'b000,
                            (rd_ptr_next == wr_ptr_next),
                            stat_next.busy,
                            stat_next.latch,
                            stat_next.data,
                            stat_next.clock};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // latch is low exactly while a frame is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[2] == !m_tdata_reg[3]))
        else $error("latch level disagrees with busy flag");

    // read pointer moves only at the end of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_ptr_reg != $past(rd_ptr_reg)) |-> $past(rd_adv))
        else $error("read pointer moved outside frame end");

    // frame end needs a serializer tick
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_adv |-> tick)
        else $error("frame ended without a tick request");

    // every accepted request leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid_reg)
        else $error("accepted request produced no result");

endmodule

`default_nettype wire

/* rtl/swq_ser.sv */
// Five-phase three-wire serializer: shifts one address/data byte pair out MSB first.
`default_nettype none

module swq_ser
    import swq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick,
    input  wire logic              pending,
    input  wire logic [BYTE_W-1:0] addr_byte,
    input  wire logic [BYTE_W-1:0] data_byte,
    output ser_stat_t              stat_next,
    output logic                   rd_adv
);

    phase_t                phase_reg,   phase_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic                  clk_lvl_reg, clk_lvl_next;
    logic                  dat_lvl_reg, dat_lvl_next;
    logic                  lat_lvl_reg, lat_lvl_next;
    logic                  last_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_idx_reg <= '0;
            clk_lvl_reg <= 1'b1;
            dat_lvl_reg <= 1'b0;
            lat_lvl_reg <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
            clk_lvl_reg <= clk_lvl_next;
            dat_lvl_reg <= dat_lvl_next;
            lat_lvl_reg <= lat_lvl_next;
        end
    end

    assign last_bit = (bit_idx_reg == '0);

    always_comb
    begin
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_lvl_next = dat_lvl_reg;
        lat_lvl_next = lat_lvl_reg;
        rd_adv       = 1'b0;
        if (tick)
        begin
            unique case (phase_reg)
                PH_SEND_ADDR:
                begin
                    clk_lvl_next = 1'b0;
                    dat_lvl_next = addr_byte[bit_idx_reg];
                    phase_next   = PH_STROBE_ADDR;
                end
                PH_STROBE_ADDR:
                begin
                    clk_lvl_next = 1'b1;
                    if (!last_bit)
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                        phase_next   = PH_SEND_ADDR;
                    end
                    else
                    begin
                        bit_idx_next = BIT_IDX_MSB;
                        phase_next   = PH_SEND_DATA;
                    end
                end
                PH_SEND_DATA:
                begin
                    clk_lvl_next = 1'b0;
                    dat_lvl_next = data_byte[bit_idx_reg];
                    phase_next   = PH_STROBE_DATA;
                end
                PH_STROBE_DATA:
                begin
                    clk_lvl_next = 1'b1;
                    if (!last_bit)
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                        phase_next   = PH_SEND_DATA;
                    end
                    else
                    begin
                        bit_idx_next = BIT_IDX_MSB;
                        phase_next   = PH_IDLE;
                        lat_lvl_next = 1'b1;
                        rd_adv       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (pending)
                    begin
                        phase_next   = PH_SEND_ADDR;
                        bit_idx_next = BIT_IDX_MSB;
                        lat_lvl_next = 1'b0;
                    end
                end
            endcase
        end
    end

    assign stat_next.clock = clk_lvl_next;
    assign stat_next.data  = dat_lvl_next;
    assign stat_next.latch = lat_lvl_next;
    assign stat_next.busy  = (phase_next != PH_IDLE);

endmodule

`default_nettype wire
